/* hdl/kanw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kanw_pkg - shared types and constants
// Field widths, the kept-entry type and the back-end state encoding for the
// k-nearest-neighbor adaptive weight unit.
// ----------------------------------------------------------------------------
package kanw_pkg;

    localparam int COL_W      = 12;
    localparam int DIST_W     = 32;
    localparam int EPS_W      = 16;
    localparam int WEIGHT_W   = 16;
    localparam int NSUM_W     = 36;
    localparam int DIV_CNT_W  = $clog2(WEIGHT_W);

    localparam logic [DIST_W-1:0]   DIST_INF   = '1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
    localparam logic [NSUM_W-1:0]   NSUM_MAX   = '1;
    localparam logic [EPS_W-1:0]    EPS_RESET  = EPS_W'(1);

    // one kept neighbor
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [DIST_W-1:0] sq_dist;
    } entry_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DENOM,
        ST_OUT,
        ST_PREP,
        ST_DIV
    } emit_state_t;

endpackage

/* hdl/kanw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kanw_front - row intake and insertion chain
// Keeps the KEEP smallest distances of the current row sorted in a register
// chain, one item per cycle while the row queue has room, and hands the row on.
// ----------------------------------------------------------------------------
module kanw_front
    import kanw_pkg::*;
#(
    parameter int KEEP        = 11,
    parameter int MAX_COLUMNS = 4096,
    parameter int CNT_W       = $clog2(KEEP + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [COL_W-1:0]      column,
    input  logic [DIST_W-1:0]     distance,
    input  logic                  is_self,
    input  logic                  row_end,
    output logic                  q_push,
    input  logic                  q_full,
    output entry_t [KEEP-1:0]     q_entries,
    output logic [CNT_W-1:0]      q_count
);

    localparam int RC_W  = $clog2(MAX_COLUMNS + 1);
    localparam int CMP_W = ((RC_W > CNT_W) ? RC_W : CNT_W) + 1;

    logic [RC_W-1:0]    row_count_reg;
    logic [RC_W-1:0]    row_count_inc;
    entry_t [KEEP-1:0]  kept_reg;
    entry_t [KEEP-1:0]  kept_next;
    entry_t             new_entry;
    logic [CNT_W-1:0]   n_cur;
    logic [CNT_W-1:0]   n_after;
    logic [KEEP-1:0]    slot_valid;
    logic [KEEP-1:0]    slot_open;
    logic               do_insert;
    logic               prev_open;
    logic               accept;

    // intake handshake: a finished row needs room in the queue
    assign full   = q_full;
    assign accept = push && !q_full;

    // self column counts as infinite
    assign new_entry.col     = column;
    assign new_entry.sq_dist = is_self ? DIST_INF : distance;

    // saturating item count and number of live entries
    assign row_count_inc = (row_count_reg == RC_W'(MAX_COLUMNS)) ?
                           row_count_reg : row_count_reg + 1'b1;
    assign n_cur   = (CMP_W'(row_count_reg) < CMP_W'(KEEP)) ?
                     CNT_W'(row_count_reg) : CNT_W'(KEEP);
    assign n_after = (CMP_W'(row_count_inc) < CMP_W'(KEEP)) ?
                     CNT_W'(row_count_inc) : CNT_W'(KEEP);

    // insertion chain: entries larger than the new one shift up by one
    always_comb
    begin
        for (int i = 0; i < KEEP; i++)
        begin
            slot_valid[i] = CNT_W'(i) < n_cur;
            slot_open[i]  = !slot_valid[i] ||
                            (kept_reg[i].sq_dist > new_entry.sq_dist);
        end
        do_insert = (n_cur < CNT_W'(KEEP)) ||
                    (new_entry.sq_dist < kept_reg[KEEP-1].sq_dist);
        prev_open = 1'b0;
        for (int i = 0; i < KEEP; i++)
        begin
            kept_next[i] = kept_reg[i];
            if (do_insert)
            begin
                if (prev_open)
                    kept_next[i] = kept_reg[(i > 0) ? i - 1 : 0];
                else if (slot_open[i])
                    kept_next[i] = new_entry;
            end
            prev_open = slot_open[i];
        end
    end

    // hand the finished row to the back end
    assign q_push    = accept && row_end;
    assign q_entries = kept_next;
    assign q_count   = n_after;

    // row count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_count_reg <= '0;
        else if (accept)
            row_count_reg <= row_end ? '0 : row_count_inc;
    end

    // kept entries
    always_ff @(posedge clk)
    begin
        if (accept)
            kept_reg <= kept_next;
    end

endmodule

/* hdl/kanw_row_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kanw_row_queue - two-row queue between intake and emission
// Holds finished rows (sorted entries and entry count) so the intake can run
// ahead of the weight computation.
// ----------------------------------------------------------------------------
module kanw_row_queue
    import kanw_pkg::*;
#(
    parameter int KEEP  = 11,
    parameter int CNT_W = $clog2(KEEP + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  entry_t [KEEP-1:0]  wr_entries,
    input  logic [CNT_W-1:0]   wr_count,
    input  logic               pop,
    output logic               empty,
    output entry_t [KEEP-1:0]  rd_entries,
    output logic [CNT_W-1:0]   rd_count
);

    entry_t [KEEP-1:0]  ent_reg [2];
    logic [CNT_W-1:0]   cnt_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         fill_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = fill_reg == 2'd2;
    assign empty   = fill_reg == 2'd0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign rd_entries = ent_reg[rd_ptr_reg];
    assign rd_count   = cnt_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 2'd1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    // row storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= wr_entries;
            cnt_reg[wr_ptr_reg] <= wr_count;
        end
    end

endmodule

/* hdl/kanw_emitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kanw_emitter - weight computation and result output
// Sums the near distances with one shared adder, forms the denominator, then
// emits the farthest entry with weight zero, then the others, whose weights
// come from a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module kanw_emitter
    import kanw_pkg::*;
#(
    parameter int NEIGHBORS = 10,
    parameter int KEEP      = NEIGHBORS + 1,
    parameter int CNT_W     = $clog2(KEEP + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [EPS_W-1:0]      epsilon,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  entry_t [KEEP-1:0]     q_entries,
    input  logic [CNT_W-1:0]      q_count,
    output logic                  empty,
    input  logic                  pop,
    output logic [COL_W-1:0]      neighbor_column,
    output logic [DIST_W-1:0]     neighbor_distance,
    output logic [WEIGHT_W-1:0]   weight,
    output logic [NSUM_W-1:0]     near_sum,
    output logic                  short_row,
    output logic                  last
);

    localparam int IDX_W = (KEEP > 1) ? $clog2(KEEP) : 1;
    localparam int SUM_W = $clog2(NEIGHBORS + 1) + DIST_W;
    localparam int DEN_W = $clog2(NEIGHBORS + 1) + DIST_W + 1;
    localparam int SAT_W = (SUM_W > NSUM_W) ? SUM_W : NSUM_W;

    emit_state_t            state_reg, state_next;
    entry_t [KEEP-1:0]      ent_reg, ent_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [DIST_W-1:0]      dmax_reg, dmax_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [DEN_W-1:0]       prod_reg, prod_next;
    logic [DEN_W-1:0]       denom_reg, denom_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       k_reg, k_next;
    logic [DEN_W:0]         rem_reg, rem_next;
    logic [WEIGHT_W-1:0]    quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]   step_reg, step_next;
    logic                   wzero_reg, wzero_next;
    logic                   wsat_reg, wsat_next;
    logic [COL_W-1:0]       res_col_reg, res_col_next;
    logic [DIST_W-1:0]      res_dist_reg, res_dist_next;
    logic [WEIGHT_W-1:0]    res_w_reg, res_w_next;

    logic [IDX_W-1:0]       n_last;
    logic [DIST_W-1:0]      diff;
    logic [DEN_W:0]         rem_sh;
    logic [SAT_W-1:0]       sum_ext;
    entry_t                 cur_entry;

    assign n_last  = IDX_W'(n_reg - 1'b1);
    assign rem_sh  = {rem_reg[DEN_W-1:0], 1'b0};
    assign sum_ext = SAT_W'(sum_reg);

    // result ports
    assign empty             = state_reg != ST_OUT;
    assign neighbor_column   = res_col_reg;
    assign neighbor_distance = res_dist_reg;
    assign weight            = res_w_reg;
    assign near_sum          = (sum_ext > SAT_W'(NSUM_MAX)) ? NSUM_MAX
                                                            : sum_ext[NSUM_W-1:0];
    assign short_row         = n_reg < CNT_W'(KEEP);
    assign last              = k_reg == n_last;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        n_reg        <= n_next;
        dmax_reg     <= dmax_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        denom_reg    <= denom_next;
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        wzero_reg    <= wzero_next;
        wsat_reg     <= wsat_next;
        res_col_reg  <= res_col_next;
        res_dist_reg <= res_dist_next;
        res_w_reg    <= res_w_next;
    end

    // sequencer: sum, denominator, then one divide per emitted neighbor after the first
    always_comb
    begin
        state_next    = state_reg;
        ent_next      = ent_reg;
        n_next        = n_reg;
        dmax_next     = dmax_reg;
        sum_next      = sum_reg;
        prod_next     = prod_reg;
        denom_next    = denom_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        step_next     = step_reg;
        wzero_next    = wzero_reg;
        wsat_next     = wsat_reg;
        res_col_next  = res_col_reg;
        res_dist_next = res_dist_reg;
        res_w_next    = res_w_reg;
        q_pop         = 1'b0;
        cur_entry     = ent_reg[IDX_W'(k_reg - 1'b1)];
        diff          = dmax_reg - cur_entry.sq_dist;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    ent_next   = q_entries;
                    n_next     = q_count;
                    dmax_next  = q_entries[IDX_W'(q_count - 1'b1)].sq_dist;
                    sum_next   = '0;
                    idx_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                prod_next = DEN_W'(dmax_reg) * DEN_W'(NEIGHBORS);
                if (idx_reg == n_last)
                    state_next = ST_DENOM;
                else
                begin
                    sum_next = sum_reg + SUM_W'(ent_reg[idx_reg].sq_dist);
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DENOM:
            begin
                denom_next    = prod_reg - DEN_W'(sum_reg) + DEN_W'(epsilon);
                k_next        = '0;
                res_col_next  = ent_reg[n_last].col;
                res_dist_next = dmax_reg;
                res_w_next    = '0;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (pop)
                begin
                    if (k_reg == n_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                res_col_next  = cur_entry.col;
                res_dist_next = cur_entry.sq_dist;
                rem_next      = (DEN_W + 1)'(diff);
                quo_next      = '0;
                step_next     = '0;
                wzero_next    = denom_reg == '0;
                wsat_next     = DEN_W'(diff) >= denom_reg;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (wzero_reg)
                begin
                    res_w_next = '0;
                    state_next = ST_OUT;
                end
                else if (wsat_reg)
                begin
                    res_w_next = WEIGHT_MAX;
                    state_next = ST_OUT;
                end
                else
                begin
                    // one quotient bit per cycle
                    if (rem_sh >= {1'b0, denom_reg})
                    begin
                        rem_next = rem_sh - {1'b0, denom_reg};
                        quo_next = {quo_reg[WEIGHT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        quo_next = {quo_reg[WEIGHT_W-2:0], 1'b0};
                    end
                    step_next = step_reg + 1'b1;
                    if (step_reg == DIV_CNT_W'(WEIGHT_W - 1))
                    begin
                        res_w_next = quo_next;
                        state_next = ST_OUT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/knn_adaptive_neighbor_weights_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_adaptive_neighbor_weights_unit - top level
// k-nearest-neighbor selection over a row of squared distances with adaptive
// neighbor weights, queue-style ports on both sides.
// ----------------------------------------------------------------------------
// The intake takes one distance per cycle into a sorted insertion chain of
// NEIGHBORS+1 entries; full is high while two finished rows wait in the row
// queue, and then holds off every input transaction until the emitter takes
// one of them. Each finished row is then emitted by a sequencer that first sums
// the near distances (n kept entries, one add per cycle), then gives each
// neighbor after the first a setup state and a 16-step restoring divider, one
// quotient bit per cycle (the divider is skipped when the weight saturates or
// the denominator is zero), and waits for the pop of every result. The first
// result of a row is the farthest kept entry with weight zero; last marks the
// final one. epsilon is written through cfg_write/cfg_data and resets to 1.
module knn_adaptive_neighbor_weights_unit
    import kanw_pkg::*;
#(
    parameter int NEIGHBORS   = 10,
    parameter int MAX_COLUMNS = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [EPS_W-1:0]      cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [COL_W-1:0]      column,
    input  logic [DIST_W-1:0]     distance,
    input  logic                  is_self,
    input  logic                  row_end,
    output logic                  empty,
    input  logic                  pop,
    output logic [COL_W-1:0]      neighbor_column,
    output logic [DIST_W-1:0]     neighbor_distance,
    output logic [WEIGHT_W-1:0]   weight,
    output logic [NSUM_W-1:0]     near_sum,
    output logic                  short_row,
    output logic                  last
);

    localparam int KEEP  = NEIGHBORS + 1;
    localparam int CNT_W = $clog2(KEEP + 1);

    logic [EPS_W-1:0]   epsilon_reg;
    logic               fq_push;
    logic               fq_full;
    entry_t [KEEP-1:0]  fq_entries;
    logic [CNT_W-1:0]   fq_count;
    logic               qe_pop;
    logic               qe_empty;
    entry_t [KEEP-1:0]  qe_entries;
    logic [CNT_W-1:0]   qe_count;

    // epsilon configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            epsilon_reg <= EPS_RESET;
        else if (cfg_write)
            epsilon_reg <= cfg_data;
    end

    // row intake
    kanw_front #(
        .KEEP        (KEEP),
        .MAX_COLUMNS (MAX_COLUMNS),
        .CNT_W       (CNT_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .column    (column),
        .distance  (distance),
        .is_self   (is_self),
        .row_end   (row_end),
        .q_push    (fq_push),
        .q_full    (fq_full),
        .q_entries (fq_entries),
        .q_count   (fq_count)
    );

    // finished rows waiting for emission
    kanw_row_queue #(
        .KEEP  (KEEP),
        .CNT_W (CNT_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fq_push),
        .full       (fq_full),
        .wr_entries (fq_entries),
        .wr_count   (fq_count),
        .pop        (qe_pop),
        .empty      (qe_empty),
        .rd_entries (qe_entries),
        .rd_count   (qe_count)
    );

    // weight computation and result output
    kanw_emitter #(
        .NEIGHBORS (NEIGHBORS),
        .KEEP      (KEEP),
        .CNT_W     (CNT_W)
    ) u_emitter (
        .clk               (clk),
        .rst_n             (rst_n),
        .epsilon           (epsilon_reg),
        .q_empty           (qe_empty),
        .q_pop             (qe_pop),
        .q_entries         (qe_entries),
        .q_count           (qe_count),
        .empty             (empty),
        .pop               (pop),
        .neighbor_column   (neighbor_column),
        .neighbor_distance (neighbor_distance),
        .weight            (weight),
        .near_sum          (near_sum),
        .short_row         (short_row),
        .last              (last)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for knn_adaptive_neighbor_weights_unit
// Streams rows of squared distances into the unit and predicts the kept
// neighbors, their adaptive weights and the row flags in a scoreboard. Every
// result transaction is checked field by field, with random idling on both
// queue ports, a long result hold-off and several epsilon settings.
// ----------------------------------------------------------------------------
module tb;
    import kanw_pkg::*;

    localparam int NEIGHBORS    = 10;
    localparam int MAX_COLUMNS  = 64;
    localparam int KEEP         = NEIGHBORS + 1;
    localparam int SETTLE       = 400;
    localparam int HOLD_OFF     = 900;
    localparam int LONG_ROW     = 70;
    localparam int REPORT_LIMIT = 40;

    typedef enum int {
        ROW_WIDE,
        ROW_TIES,
        ROW_EDGES
    } row_style_t;

    // one emitted neighbor as seen on the result ports
    typedef struct packed {
        logic [COL_W-1:0]    col;
        logic [DIST_W-1:0]   sq_dist;
        logic [WEIGHT_W-1:0] wt;
        logic [NSUM_W-1:0]   nsum;
        logic                short_r;
        logic                lst;
    } neighbor_result_t;

    // kept-neighbor predictor and result checker
    class neighbor_weight_scoreboard;
        entry_t           kept[KEEP];
        int unsigned      row_items;
        logic [EPS_W-1:0] eps;
        neighbor_result_t expected_neighbors[$];
        int unsigned      mismatches;
        int unsigned      inputs_noted;
        int unsigned      rows_closed;
        int unsigned      neighbors_checked;

        function new();
            foreach (kept[k])
                kept[k] = '0;
            row_items         = 0;
            eps               = EPS_RESET;
            mismatches        = 0;
            inputs_noted      = 0;
            rows_closed       = 0;
            neighbors_checked = 0;
        endfunction

        function void set_epsilon(input logic [EPS_W-1:0] value);
            eps = value;
        endfunction

        // sorted insert of one distance; on the row end, queue the row's neighbors
        function void note_distance(input logic [COL_W-1:0] col,
                                    input logic [DIST_W-1:0] dist_in,
                                    input logic self_flag,
                                    input logic end_flag);
            logic [DIST_W-1:0] dist_eff;
            int unsigned       n;
            int unsigned       top;
            int unsigned       p;
            int unsigned       i;
            logic [63:0]       dmax;
            logic [63:0]       total;
            logic [63:0]       denom;
            logic [63:0]       quot;
            entry_t            e;
            neighbor_result_t  r;

            dist_eff = self_flag ? DIST_INF : dist_in;
            inputs_noted++;
            n = (row_items < KEEP) ? row_items : KEEP;

            // later arrivals sort after equal distances
            if (n < KEEP || dist_eff < kept[KEEP-1].sq_dist)
            begin
                top = (n < KEEP) ? n : KEEP - 1;
                p = 0;
                while (p < top && kept[p].sq_dist <= dist_eff)
                    p++;
                for (i = top; i > p; i--)
                    kept[i] = kept[i-1];
                kept[p].col     = col;
                kept[p].sq_dist = dist_eff;
            end
            if (row_items < MAX_COLUMNS)
                row_items++;
            if (!end_flag)
                return;

            // weights over the kept set
            n = (row_items < KEEP) ? row_items : KEEP;
            dmax = 64'(kept[n-1].sq_dist);
            total = '0;
            for (i = 0; i + 1 < n; i++)
                total += 64'(kept[i].sq_dist);
            denom = 64'(NEIGHBORS) * dmax - total + 64'(eps);

            for (i = 0; i < n; i++)
            begin
                e = (i == 0) ? kept[n-1] : kept[i-1];
                r.col     = e.col;
                r.sq_dist = e.sq_dist;
                r.wt      = '0;
                if (i != 0 && denom != 0)
                begin
                    quot = ((dmax - 64'(e.sq_dist)) << 16) / denom;
                    r.wt = (quot > 64'(WEIGHT_MAX)) ? WEIGHT_MAX : quot[WEIGHT_W-1:0];
                end
                r.nsum    = (total > 64'(NSUM_MAX)) ? NSUM_MAX : total[NSUM_W-1:0];
                r.short_r = (row_items < KEEP);
                r.lst     = (i + 1 == n);
                expected_neighbors.push_back(r);
            end
            rows_closed++;
            row_items = 0;
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] neighbor check failed: %s", $time, what);
        endtask

        // compare one result transaction with the oldest expected neighbor
        task check_neighbor(input neighbor_result_t got);
            neighbor_result_t want;

            if (expected_neighbors.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing expected, column %0d",
                                          got.col));
                return;
            end
            want = expected_neighbors.pop_front();
            neighbors_checked++;
            if (got.col !== want.col)
                report_mismatch($sformatf("neighbor_column got %0d want %0d",
                                          got.col, want.col));
            if (got.sq_dist !== want.sq_dist)
                report_mismatch($sformatf("neighbor_distance got %h want %h",
                                          got.sq_dist, want.sq_dist));
            if (got.wt !== want.wt)
                report_mismatch($sformatf("weight got %h want %h (column %0d)",
                                          got.wt, want.wt, want.col));
            if (got.nsum !== want.nsum)
                report_mismatch($sformatf("near_sum got %h want %h",
                                          got.nsum, want.nsum));
            if (got.short_r !== want.short_r)
                report_mismatch($sformatf("short_row got %b want %b",
                                          got.short_r, want.short_r));
            if (got.lst !== want.lst)
                report_mismatch($sformatf("last got %b want %b", got.lst, want.lst));
        endtask
    endclass

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_write = 1'b0;
    logic [EPS_W-1:0]    cfg_data  = '0;
    logic                push      = 1'b0;
    logic                full;
    logic [COL_W-1:0]    column    = '0;
    logic [DIST_W-1:0]   distance  = '0;
    logic                is_self   = 1'b0;
    logic                row_end   = 1'b0;
    logic                empty;
    logic                pop       = 1'b0;
    logic [COL_W-1:0]    neighbor_column;
    logic [DIST_W-1:0]   neighbor_distance;
    logic [WEIGHT_W-1:0] weight;
    logic [NSUM_W-1:0]   near_sum;
    logic                short_row;
    logic                last;

    neighbor_weight_scoreboard sb;
    bit          tx_burst          = 1'b0;
    int unsigned hold_request      = 0;
    int unsigned items_sent        = 0;
    int unsigned full_stall_cycles = 0;
    int unsigned eps_settings      = 0;

    knn_adaptive_neighbor_weights_unit #(
        .NEIGHBORS   (NEIGHBORS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_data          (cfg_data),
        .push              (push),
        .full              (full),
        .column            (column),
        .distance          (distance),
        .is_self           (is_self),
        .row_end           (row_end),
        .empty             (empty),
        .pop               (pop),
        .neighbor_column   (neighbor_column),
        .neighbor_distance (neighbor_distance),
        .weight            (weight),
        .near_sum          (near_sum),
        .short_row         (short_row),
        .last              (last)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;

        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 48);
    endfunction

    function automatic int unsigned pick_row_len();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(1, 10);
            3, 4, 5: return $urandom_range(11, 12);
            6, 7, 8: return $urandom_range(13, 40);
            default: return $urandom_range(41, 120);
        endcase
    endfunction

    function automatic row_style_t pick_style();
        return row_style_t'($urandom_range(0, 2));
    endfunction

    // one input transaction, waiting out full
    task automatic send_distance(input logic [COL_W-1:0] c,
                                 input logic [DIST_W-1:0] d,
                                 input logic s,
                                 input logic e);
        int unsigned g;

        g = tx_burst ? 0 : pick_gap();
        if (g != 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
        push     <= 1'b1;
        column   <= c;
        distance <= d;
        is_self  <= s;
        row_end  <= e;
        @(posedge clk);
        while (full)
        begin
            full_stall_cycles++;
            @(posedge clk);
        end
        sb.note_distance(c, d, s, e);
        items_sent++;
    endtask

    task automatic send_random_row(input int unsigned len,
                                   input row_style_t style,
                                   input bit no_idle);
        logic [COL_W-1:0]  base;
        logic [COL_W-1:0]  c;
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] v;
        int unsigned       i;

        base = COL_W'($urandom);
        v = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
        tx_burst = no_idle || ($urandom_range(0, 4) == 0);
        for (i = 0; i < len; i++)
        begin
            case (style)
                ROW_WIDE: d = $urandom;
                ROW_TIES: d = ($urandom_range(0, 3) == 0) ? v + 1 : v;
                default:
                    case ($urandom_range(0, 5))
                        0:       d = '0;
                        1:       d = DIST_INF;
                        2:       d = $urandom_range(0, 255);
                        default: d = $urandom;
                    endcase
            endcase
            c = ($urandom_range(0, 7) == 0) ? COL_W'($urandom) : base + COL_W'(i);
            send_distance(c, d, $urandom_range(0, 19) == 0, i + 1 == len);
        end
    endtask

    // wait for every expected neighbor, then let the unit settle
    task automatic drain_results();
        push <= 1'b0;
        while (sb.expected_neighbors.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_epsilon(input logic [EPS_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_epsilon(value);
        eps_settings++;
    endtask

    // stimulus
    initial
    begin : stimulus
        int unsigned i;
        int unsigned phase_end;

        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, self entry, ties and a late replacement at reset epsilon
        send_distance(12'hFFF, 32'h0, 1'b0, 1'b1);
        send_distance(12'h000, 32'h1234_5678, 1'b1, 1'b0);
        send_distance(12'h001, DIST_INF, 1'b0, 1'b1);
        for (i = 0; i < 12; i++)
            send_distance(COL_W'(i + 100), (i == 11) ? 32'd3 : 32'd5, i == 6, i == 11);
        drain_results();

        // zero denominator and a saturated weight
        write_epsilon('0);
        send_distance(12'h02A, 32'h0, 1'b0, 1'b0);
        send_distance(12'h02B, 32'h0, 1'b0, 1'b1);
        for (i = 0; i < 11; i++)
            send_distance(COL_W'(i + 200), (i == 0) ? 32'd7 : 32'd100, 1'b0, i == 10);
        drain_results();

        // largest epsilon; short rows pile up behind a long result hold-off
        write_epsilon('1);
        hold_request = HOLD_OFF;
        for (i = 0; i < 24; i++)
            send_random_row($urandom_range(1, 3), ROW_EDGES, 1'b0);
        phase_end = items_sent + 80;
        while (items_sent < phase_end)
            send_random_row(pick_row_len(), pick_style(), 1'b0);
        drain_results();

        // random epsilon values, one row long enough to pass the column limit
        for (i = 0; i < 3; i++)
        begin
            write_epsilon(EPS_W'($urandom));
            phase_end = items_sent + 30;
            while (items_sent < phase_end)
                send_random_row(pick_row_len(), pick_style(), 1'b0);
            if (i == 1)
                send_random_row(LONG_ROW, ROW_WIDE, 1'b1);
            drain_results();
        end

        // zero epsilon with tie-heavy rows
        write_epsilon('0);
        phase_end = items_sent + 60;
        while (items_sent < phase_end)
            send_random_row(pick_row_len(),
                            ($urandom_range(0, 2) == 0) ? pick_style() : ROW_TIES, 1'b0);
        drain_results();

        $display("covered %0d distance transactions in %0d rows, %0d neighbor results checked",
                 sb.inputs_noted, sb.rows_closed, sb.neighbors_checked);
        $display("epsilon written %0d times, input held off by full for %0d cycles",
                 eps_settings, full_stall_cycles);
        if (sb.mismatches == 0 && sb.expected_neighbors.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random pops, bursts and the requested hold-off
    initial
    begin : result_sink
        int unsigned      wait_left;
        int unsigned      hold_left;
        int unsigned      since_mode;
        bit               rx_burst;
        neighbor_result_t got;

        wait_left  = 0;
        hold_left  = 0;
        since_mode = 0;
        rx_burst   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got = '{neighbor_column, neighbor_distance, weight, near_sum,
                        short_row, last};
                sb.check_neighbor(got);
                wait_left = rx_burst ? 0 : pick_gap();
                since_mode++;
                if (since_mode == 48)
                begin
                    since_mode = 0;
                    rx_burst = ($urandom_range(0, 3) == 0);
                end
            end
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (wait_left != 0)
            begin
                pop <= 1'b0;
                wait_left--;
            end
            else
                pop <= 1'b1;
        end
    end

    // run limit
    initial
    begin : watchdog
        #3_000_000;
        $display("timeout: %0d neighbor results still expected",
                 sb.expected_neighbors.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
